// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/hhfv_pkg.sv =====
package hhfv_pkg;

	// Item modes
	localparam logic [1:0] MODE_NAME  = 2'd0;
	localparam logic [1:0] MODE_VALUE = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// Result kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict status codes
	localparam logic [2:0] STATUS_OK         = 3'd0;
	localparam logic [2:0] STATUS_EMPTY_NAME = 3'd1;
	localparam logic [2:0] STATUS_BAD_NAME   = 3'd2;
	localparam logic [2:0] STATUS_BAD_VALUE  = 3'd3;
	localparam logic [2:0] STATUS_WS_REJECT  = 3'd4;
	localparam logic [2:0] STATUS_RUN_OVF    = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_UNDERSCORE    = 2'd0;
	localparam logic [1:0] CFG_REJECT_CLIENT = 2'd1;
	localparam logic [1:0] CFG_REJECT_UPSTR  = 2'd2;

	// Character codes
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_LF         = 8'h0a;
	localparam logic [7:0] CH_CR         = 8'h0d;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_DASH       = 8'h2d;
	localparam logic [7:0] CH_COLON      = 8'h3a;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_DEL        = 8'h7f;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       from_client;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic [2:0]  status;
		logic        odd_name;
		logic [15:0] value_length;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_DRAIN,
		S_EMIT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic drain_load;
		logic emit_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic drain_req;
		logic emit_req;
		logic drain_last;
		logic out_free;
	} dp_stat_t;

	// First error wins, but a bad value replaces a whitespace or overflow status
	function automatic logic [2:0] raise_status(input logic [2:0] cur, input logic [2:0] code);
		logic [2:0] res;
		res = cur;
		if (cur == STATUS_OK ||
				(code == STATUS_BAD_VALUE &&
				(cur == STATUS_WS_REJECT || cur == STATUS_RUN_OVF))) begin
			res = code;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/hhfv_ctrl.sv =====
`include "assert_macros.svh"

module hhfv_ctrl import hhfv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance from idle through fetch and drain to emit, or straight to emit
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (stat.drain_req) begin
						state_d = S_FETCH;
					end else if (stat.emit_req) begin
						state_d = S_EMIT;
					end
				end
			end
			S_FETCH: begin
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (stat.out_free && stat.drain_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Drive commands
	always_comb begin
		item_stall     = (state_q != S_IDLE);
		cmd.take       = item_valid && (state_q == S_IDLE);
		cmd.drain_load = (state_q == S_DRAIN) && stat.out_free;
		cmd.emit_load  = (state_q == S_EMIT) && stat.out_free;
	end

	`ASSERT_NEXT(a_fetch_then_drain, state_q == S_FETCH, state_q == S_DRAIN, "fetch not followed by drain")
	`ASSERT_NEXT(a_emit_done_idle, cmd.emit_load, state_q == S_IDLE, "emit load did not return to idle")
	`ASSERT_IMPL(a_take_unstalled, cmd.take, !item_stall, "item taken while stalled")

endmodule

// ===== hw/rtl/hhfv_dp.sv =====
`include "assert_macros.svh"

module hhfv_dp import hhfv_pkg::*; #(
	parameter int MAX_SPACE_RUN = 63,
	parameter int LENGTH_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  item_t      item,
	input  logic       result_stall,
	output logic       result_valid,
	output result_t    result,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat
);

	localparam int CNT_W = $clog2(MAX_SPACE_RUN + 1);
	localparam int IDX_W = (MAX_SPACE_RUN > 1) ? $clog2(MAX_SPACE_RUN) : 1;
	localparam logic [CNT_W-1:0] RUN_MAX = CNT_W'(MAX_SPACE_RUN);
	localparam logic [LENGTH_BITS-1:0] LEN_SAT = {LENGTH_BITS{1'b1}};

	// Configuration registers
	logic cfg_underscore_q;
	logic cfg_reject_client_q;
	logic cfg_reject_upstr_q;

	// Per-header state
	logic                   in_header_q;
	logic                   first_name_q;
	logic                   name_seen_q;
	logic                   client_q;
	logic                   reject_q;
	logic [2:0]             err_q;
	logic                   odd_q;
	logic                   content_q;
	logic [CNT_W-1:0]       run_cnt_q;
	logic [LENGTH_BITS-1:0] len_q;

	// Drain and output
	logic             run_mem [MAX_SPACE_RUN];
	logic [CNT_W-1:0] drain_total_q;
	logic [CNT_W-1:0] drain_idx_q;
	logic             rd_q;
	result_t          pend_q;
	result_t          out_q;
	logic             out_valid_q;

	// Item decode
	logic             client_eff;
	logic             reject_eff;
	logic [7:0]       b;
	logic             is_ws;
	logic             is_bad_val;
	logic             name_ok;
	logic             name_bad;
	logic             is_name;
	logic             is_val;
	logic             is_end;
	logic             colon_skip;
	logic             val_content;
	logic             ws_emit;
	logic             ws_hold;
	logic [2:0]       raise_code;
	logic [2:0]       err_d;
	logic [2:0]       verdict_status;
	logic [LENGTH_BITS+15:0] len_ext;
	logic [15:0]      len_out;
	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W-1:0] rd_addr;
	logic             load;
	result_t          drain_res;
	result_t          load_res;
	result_t          byte_res;
	result_t          verdict_res;

	// Classify the offered item
	always_comb begin
		client_eff  = in_header_q ? client_q : item.from_client;
		reject_eff  = in_header_q ? reject_q :
			(item.from_client ? cfg_reject_client_q : cfg_reject_upstr_q);
		b           = item.data;
		is_name     = (item.mode == MODE_NAME);
		is_val      = (item.mode == MODE_VALUE);
		is_end      = (item.mode == MODE_END);
		is_ws       = (b == CH_SPACE) || (b == CH_TAB);
		is_bad_val  = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
		name_ok     = client_eff && (((b >= 8'h61) && (b <= 8'h7a)) || (b == CH_DASH) ||
			((b >= 8'h30) && (b <= 8'h39)) || ((b == CH_UNDERSCORE) && cfg_underscore_q));
		name_bad    = (b <= CH_SPACE) || (b == CH_DEL) || (b == CH_COLON) ||
			((b >= 8'h41) && (b <= 8'h5a));
		colon_skip  = first_name_q && (b == CH_COLON);
		val_content = is_val && !is_ws;
		ws_emit     = is_val && is_ws && content_q && reject_eff;
		ws_hold     = is_val && is_ws && content_q && !reject_eff && (run_cnt_q < RUN_MAX);
	end

	// Pick the status this item raises
	always_comb begin
		raise_code = STATUS_OK;
		priority if (is_name && !colon_skip && !name_ok && name_bad) begin
			raise_code = STATUS_BAD_NAME;
		end else if (is_val && is_bad_val) begin
			raise_code = STATUS_BAD_VALUE;
		end else if (is_val && is_ws && !content_q && reject_eff) begin
			raise_code = STATUS_WS_REJECT;
		end else if (is_val && is_ws && content_q && !reject_eff && !ws_hold) begin
			raise_code = STATUS_RUN_OVF;
		end else begin
			raise_code = STATUS_OK;
		end
		err_d = (raise_code != STATUS_OK) ? raise_status(err_q, raise_code) : err_q;
	end

	// Build the verdict
	always_comb begin
		len_ext = {16'd0, len_q};
		len_out = (|len_ext[LENGTH_BITS+15:16]) ? 16'hffff : len_ext[15:0];
		verdict_status = name_seen_q ? err_q : STATUS_EMPTY_NAME;
		if (verdict_status == STATUS_OK && reject_eff && (run_cnt_q != '0)) begin
			verdict_status = STATUS_WS_REJECT;
		end
		byte_res = '0;
		byte_res.kind = KIND_BYTE;
		byte_res.out_byte = b;
		verdict_res = '0;
		verdict_res.kind = KIND_VERDICT;
		verdict_res.status = verdict_status;
		verdict_res.odd_name = client_eff && odd_q;
		verdict_res.value_length = len_out;
		verdict_res.last = 1'b1;
	end

	// Drain read and output selection
	always_comb begin
		idx_inc  = drain_idx_q + CNT_W'(1);
		stat.drain_last = (idx_inc == drain_total_q);
		stat.out_free   = !out_valid_q || !result_stall;
		stat.drain_req  = val_content && !reject_eff && (run_cnt_q != '0);
		stat.emit_req   = ws_emit || val_content || is_end;
		rd_addr  = (cmd.drain_load && !stat.drain_last) ? idx_inc : drain_idx_q;
		drain_res = '0;
		drain_res.kind = KIND_BYTE;
		drain_res.out_byte = rd_q ? CH_TAB : CH_SPACE;
		load     = cmd.drain_load || cmd.emit_load;
		load_res = cmd.drain_load ? drain_res : pend_q;
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_underscore_q    <= 1'b0;
			cfg_reject_client_q <= 1'b0;
			cfg_reject_upstr_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNDERSCORE:    cfg_underscore_q    <= cfg_data;
				CFG_REJECT_CLIENT: cfg_reject_client_q <= cfg_data;
				CFG_REJECT_UPSTR:  cfg_reject_upstr_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Update header state on each taken item other than mode 3, and the drain index and length on loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q   <= 1'b0;
			first_name_q  <= 1'b1;
			name_seen_q   <= 1'b0;
			client_q      <= 1'b0;
			reject_q      <= 1'b0;
			err_q         <= STATUS_OK;
			odd_q         <= 1'b0;
			content_q     <= 1'b0;
			run_cnt_q     <= '0;
			len_q         <= '0;
			drain_total_q <= '0;
			drain_idx_q   <= '0;
		end else begin
			if (cmd.drain_load) begin
				drain_idx_q <= idx_inc;
			end
			if (load && (load_res.kind == KIND_BYTE) && (len_q != LEN_SAT)) begin
				len_q <= len_q + LENGTH_BITS'(1);
			end
			if (cmd.take && (item.mode != MODE_NONE)) begin
				if (is_end) begin
					in_header_q  <= 1'b0;
					first_name_q <= 1'b1;
					name_seen_q  <= 1'b0;
					client_q     <= 1'b0;
					reject_q     <= 1'b0;
					err_q        <= STATUS_OK;
					odd_q        <= 1'b0;
					content_q    <= 1'b0;
					run_cnt_q    <= '0;
					len_q        <= '0;
				end else begin
					in_header_q <= 1'b1;
					client_q    <= client_eff;
					reject_q    <= reject_eff;
					err_q       <= err_d;
					if (is_name) begin
						name_seen_q  <= 1'b1;
						first_name_q <= 1'b0;
						if (!colon_skip && (err_q == STATUS_OK) && !name_ok && !name_bad &&
								client_eff) begin
							odd_q <= 1'b1;
						end
					end
					if (ws_emit && (run_cnt_q < RUN_MAX)) begin
						run_cnt_q <= run_cnt_q + CNT_W'(1);
					end
					if (ws_hold) begin
						run_cnt_q <= run_cnt_q + CNT_W'(1);
					end
					if (val_content) begin
						drain_total_q <= run_cnt_q;
						drain_idx_q   <= '0;
						run_cnt_q     <= '0;
						content_q     <= 1'b1;
					end
				end
			end
		end
	end

	// Store held whitespace, read the run store, latch the pending result and load the output
	always_ff @(posedge clk) begin
		if (cmd.take && ws_hold) begin
			run_mem[run_cnt_q[IDX_W-1:0]] <= (b == CH_TAB);
		end
		rd_q <= run_mem[rd_addr[IDX_W-1:0]];
		if (cmd.take) begin
			pend_q <= is_end ? verdict_res : byte_res;
		end
		if (load) begin
			out_q <= load_res;
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`ASSERT_CLK(a_run_bound, run_cnt_q <= RUN_MAX, "held run count above limit")
	`ASSERT_IMPL(a_load_free, load, !out_valid_q || !result_stall, "output overwritten")
	`ASSERT_IMPL(a_drain_range, cmd.drain_load, drain_idx_q < drain_total_q, "drain past run")

endmodule

// ===== hw/rtl/http_header_field_validator_top.sv =====
// HTTP header field validator. Feed one header as name words (mode 0), value
// words (mode 1) and one end word (mode 2); mode 3 words are taken and ignored.
// Value words come back stripped of leading and trailing space/tab (or, in
// reject mode, with leading ones dropped, the rest kept, and a whitespace
// status if there was leading or trailing space/tab), then one verdict word
// with last set; a nonzero verdict status means the streamed bytes are to be
// dropped. Name words, held or dropped whitespace words and mode 3 words give
// no output and leave the block idle. A word with output is taken, then loaded
// when the output register is free; a content byte that releases a held run
// is taken, then passes fetch, drain and emit, the run read back through a
// registered read one entry per cycle while the output is free. Configuration
// writes are always accepted and must only be issued while the block is idle.
module http_header_field_validator_top import hhfv_pkg::*; #(
	parameter int MAX_SPACE_RUN = 63,
	parameter int LENGTH_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     cfg_we;

	// Take register writes in any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	hhfv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	hhfv_dp #(
		.MAX_SPACE_RUN (MAX_SPACE_RUN),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

// ===== verif/http_header_field_validator_top_tb.sv =====
`timescale 1ns / 100ps

module http_header_field_validator_top_tb;
	import hhfv_pkg::*;

	localparam int HELD_RUN_DEPTH  = 63;
	localparam int SETTLE_CYCLES   = 80;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 62;
	localparam int DIRECTED_COUNT  = 24;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic       cfg_data;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall;
	result_t    result;

	http_header_field_validator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// One directed row: the word to send and, where obvious, the verdict it must give
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  data;
		logic        client;
		logic        typed;
		logic [2:0]  status;
		logic        flag;
		logic [15:0] vlen;
	} directed_row_t;

	// Per sent word: whether the verdict is typed in rather than computed
	typedef struct {
		bit      typed;
		result_t verdict;
	} word_note_t;

	directed_row_t directed_rows [DIRECTED_COUNT] = '{
		// lone end word: no name at all
		'{MODE_END,   8'h00,         1'b0, 1'b1, STATUS_EMPTY_NAME, 1'b0, 16'd0},
		// uppercase letter in a client name
		'{MODE_NAME,  8'h41,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_END,   8'hff,         1'b1, 1'b1, STATUS_BAD_NAME,   1'b0, 16'd0},
		// pseudo-header, odd byte, leading/inner/trailing whitespace
		'{MODE_NAME,  CH_COLON,      1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_NAME,  8'h78,         1'b0, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_NAME,  8'hff,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_SPACE,      1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, 8'h76,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_TAB,        1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_SPACE,      1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, 8'hff,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_SPACE,      1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_END,   8'h00,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		// upstream DEL, bad value bytes, ignored word, name after value
		'{MODE_NAME,  CH_DEL,        1'b0, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_NUL,        1'b0, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_NONE,  8'haa,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_LF,         1'b0, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_NAME,  CH_COLON,      1'b0, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_END,   8'h00,         1'b0, 1'b0, STATUS_OK,         1'b0, 16'd0},
		// underscore while disabled, then errors that must not move the flag
		'{MODE_NAME,  CH_UNDERSCORE, 1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_NAME,  CH_SPACE,      1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_NAME,  8'h7a,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_VALUE, CH_CR,         1'b1, 1'b0, STATUS_OK,         1'b0, 16'd0},
		'{MODE_END,   8'h00,         1'b1, 1'b1, STATUS_BAD_NAME,   1'b1, 16'd1}
	};

	word_note_t word_notes [$];
	result_t    header_results_due [$];
	result_t    fresh_results [$];

	// Register copies and per-header state of the checker
	logic       underscore_ok;
	logic       reject_client_cfg;
	logic       reject_upstream_cfg;
	logic       hdr_open;
	logic       hdr_first_name;
	logic       hdr_name_seen;
	logic       hdr_client;
	logic       hdr_reject;
	logic       hdr_odd;
	logic       hdr_content;
	logic [2:0] hdr_err;
	logic       ws_is_tab [HELD_RUN_DEPTH];
	int         ws_held;
	logic [15:0] value_count;

	bit          idling;
	int unsigned result_hold;
	int unsigned cycles;
	int          mismatches;
	int          words_offered;
	int          words_taken;
	int          headers_sent;
	int          results_checked;
	int          failed_verdicts;
	int          settings_applied;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_header_state();
		hdr_open       = 1'b0;
		hdr_first_name = 1'b1;
		hdr_name_seen  = 1'b0;
		hdr_client     = 1'b0;
		hdr_reject     = 1'b0;
		hdr_odd        = 1'b0;
		hdr_content    = 1'b0;
		hdr_err        = STATUS_OK;
		ws_held        = 0;
		value_count    = '0;
	endfunction

	// Keep the first status, but let a bad value override whitespace or overflow
	function automatic void keep_first_status(input logic [2:0] code);
		if (hdr_err == STATUS_OK || (code == STATUS_BAD_VALUE &&
				(hdr_err == STATUS_WS_REJECT || hdr_err == STATUS_RUN_OVF))) begin
			hdr_err = code;
		end
	endfunction

	function automatic void stream_value_byte(input logic [7:0] b);
		result_t r;
		r.kind           = KIND_BYTE;
		r.out_byte       = b;
		r.status         = STATUS_OK;
		r.odd_name       = 1'b0;
		r.value_length   = '0;
		r.last           = 1'b0;
		fresh_results.push_back(r);
		if (value_count != 16'hffff) begin
			value_count++;
		end
	endfunction

	function automatic void check_name_byte(input logic [7:0] b);
		if (hdr_err != STATUS_OK) begin
			return;
		end
		// lowercase, digit, dash and (if enabled) underscore pass for clients
		if (hdr_client && ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h30 && b <= 8'h39) ||
				b == CH_DASH || (b == CH_UNDERSCORE && underscore_ok))) begin
			return;
		end
		if (b <= CH_SPACE || b == CH_DEL || b == CH_COLON || (b >= 8'h41 && b <= 8'h5a)) begin
			keep_first_status(STATUS_BAD_NAME);
		end else if (hdr_client) begin
			hdr_odd = 1'b1;
		end
	endfunction

	// Work out the result words that one accepted word causes
	function automatic void validate_header_word(input item_t w);
		logic [2:0] verdict_status;
		result_t    v;
		if (w.mode == MODE_NONE) begin
			return;
		end
		if (!hdr_open) begin
			hdr_open   = 1'b1;
			hdr_client = w.from_client;
			hdr_reject = w.from_client ? reject_client_cfg : reject_upstream_cfg;
		end
		case (w.mode)
			MODE_NAME: begin
				hdr_name_seen = 1'b1;
				if (!(hdr_first_name && w.data == CH_COLON)) begin
					check_name_byte(w.data);
				end
				hdr_first_name = 1'b0;
			end
			MODE_VALUE: begin
				if (w.data == CH_NUL || w.data == CH_LF || w.data == CH_CR) begin
					keep_first_status(STATUS_BAD_VALUE);
				end
				if (w.data == CH_SPACE || w.data == CH_TAB) begin
					if (!hdr_content) begin
						if (hdr_reject) begin
							keep_first_status(STATUS_WS_REJECT);
						end
					end else if (hdr_reject) begin
						stream_value_byte(w.data);
						if (ws_held < HELD_RUN_DEPTH) begin
							ws_held++;
						end
					end else if (ws_held < HELD_RUN_DEPTH) begin
						ws_is_tab[ws_held] = (w.data == CH_TAB);
						ws_held++;
					end else begin
						keep_first_status(STATUS_RUN_OVF);
					end
				end else begin
					// release the held run ahead of the content byte
					if (!hdr_reject) begin
						for (int i = 0; i < ws_held; i++) begin
							stream_value_byte(ws_is_tab[i] ? CH_TAB : CH_SPACE);
						end
					end
					ws_held = 0;
					stream_value_byte(w.data);
					hdr_content = 1'b1;
				end
			end
			default: begin
				verdict_status = hdr_name_seen ? hdr_err : STATUS_EMPTY_NAME;
				if (verdict_status == STATUS_OK && hdr_reject && ws_held > 0) begin
					verdict_status = STATUS_WS_REJECT;
				end
				v.kind           = KIND_VERDICT;
				v.out_byte       = '0;
				v.status         = verdict_status;
				v.odd_name       = hdr_client && hdr_odd;
				v.value_length   = value_count;
				v.last           = 1'b1;
				fresh_results.push_back(v);
				clear_header_state();
			end
		endcase
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Track register writes, predict accepted words, check result words
	always @(posedge clk) begin
		word_note_t note;
		result_t    want;
		if (!arst_n) begin
			underscore_ok       = 1'b0;
			reject_client_cfg   = 1'b0;
			reject_upstream_cfg = 1'b0;
			clear_header_state();
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_UNDERSCORE:    underscore_ok = cfg_data;
				CFG_REJECT_CLIENT: reject_client_cfg = cfg_data;
				CFG_REJECT_UPSTR:  reject_upstream_cfg = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && item_valid && !item_stall) begin
			note = word_notes.pop_front();
			fresh_results.delete();
			validate_header_word(item);
			if (note.typed) begin
				header_results_due.push_back(note.verdict);
			end else begin
				foreach (fresh_results[i]) begin
					header_results_due.push_back(fresh_results[i]);
				end
			end
			words_taken++;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (header_results_due.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				want = header_results_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("out_byte", 32'(want.out_byte), 32'(result.out_byte));
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("odd_name", 32'(want.odd_name), 32'(result.odd_name));
				check_field("value_length", 32'(want.value_length), 32'(result.value_length));
				check_field("last", 32'(want.last), 32'(result.last));
				if (want.kind == KIND_VERDICT && want.status != STATUS_OK) begin
					failed_verdicts++;
				end
			end
			results_checked++;
		end
	end

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (result_hold != 0) begin
			result_hold--;
			result_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			result_hold = $urandom_range(0, 9);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d result words still due", cycles,
				header_results_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one word, with an optional idle burst first, and hold it until taken
	task automatic send_word(input logic [1:0] m, input logic [7:0] d, input logic c,
			input bit typed = 1'b0, input result_t verdict = '0);
		word_note_t note;
		item_t      w;
		note.typed   = typed;
		note.verdict = verdict;
		w.mode       = m;
		w.data       = d;
		w.from_client = c;
		if (idling && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		word_notes.push_back(note);
		if (m != MODE_NONE) begin
			words_offered++;
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// Write all three registers back to back
	task automatic apply_settings(input logic [2:0] knobs);
		logic [1:0] reg_index [3];
		reg_index = '{CFG_UNDERSCORE, CFG_REJECT_CLIENT, CFG_REJECT_UPSTR};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_index[i];
			cfg_data  <= knobs[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// Wait for every due result, then let a held run drain out
	task automatic drain_and_settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (header_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] ws_byte();
		return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
	endfunction

	// Mostly the latched source, sometimes the other one to probe the latch
	function automatic logic client_tag(input logic c);
		return ($urandom_range(0, 7) == 0) ? !c : c;
	endfunction

	function automatic logic [7:0] pick_name_byte();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 9) begin
			return 8'(8'h61 + $urandom_range(0, 25));
		end else if (r < 12) begin
			return 8'(8'h30 + $urandom_range(0, 9));
		end else if (r == 12) begin
			return CH_DASH;
		end else if (r == 13) begin
			return CH_UNDERSCORE;
		end else if (r < 17) begin
			return 8'($urandom_range(8'h21, 8'h7e));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_content_byte();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			case ($urandom_range(0, 2))
				0: return CH_NUL;
				1: return CH_CR;
				default: return CH_LF;
			endcase
		end else if (r == 1) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(8'h21, 8'h7e));
	endfunction

	// One header: mostly well formed with random content, sometimes noise
	task automatic send_random_header();
		logic c;
		int   name_len;
		int   segs;
		c = 1'($urandom_range(0, 1));
		headers_sent++;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
			send_word(MODE_END, 8'($urandom_range(0, 255)), c);
			return;
		end
		if ($urandom_range(0, 2) == 0) begin
			send_word(MODE_NAME, CH_COLON, c);
		end
		name_len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
		repeat (name_len) send_word(MODE_NAME, pick_name_byte(), client_tag(c));
		if ($urandom_range(0, 1) != 0) begin
			repeat ($urandom_range(1, 3)) send_word(MODE_VALUE, ws_byte(), client_tag(c));
		end
		segs = $urandom_range(0, 4);
		repeat (segs) begin
			repeat ($urandom_range(1, 5)) send_word(MODE_VALUE, pick_content_byte(), client_tag(c));
			// an occasional run near or past the depth of the held store
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(60, 68)) send_word(MODE_VALUE, ws_byte(), client_tag(c));
			end else begin
				repeat ($urandom_range(0, 3)) send_word(MODE_VALUE, ws_byte(), client_tag(c));
			end
		end
		send_word(MODE_END, 8'($urandom_range(0, 255)), client_tag(c));
	endtask

	initial begin
		result_t    typed_verdict;
		logic [2:0] knobs;
		int         phase_start;
		arst_n              = 1'b0;
		cfg_valid           = 1'b0;
		cfg_index           = CFG_UNDERSCORE;
		cfg_data            = 1'b0;
		item_valid          = 1'b0;
		item                = '0;
		idling              = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words with all registers cleared
		apply_settings(3'b000);
		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			typed_verdict.kind           = KIND_VERDICT;
			typed_verdict.out_byte       = '0;
			typed_verdict.status         = directed_rows[r].status;
			typed_verdict.odd_name       = directed_rows[r].flag;
			typed_verdict.value_length   = directed_rows[r].vlen;
			typed_verdict.last           = 1'b1;
			send_word(directed_rows[r].mode, directed_rows[r].data, directed_rows[r].client,
				directed_rows[r].typed, typed_verdict);
		end
		drain_and_settle();

		// Random headers under a new setting per phase; the last phase runs flat out
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idling = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (p == 0) begin
				knobs = 3'b111;
			end else if (p == 1) begin
				knobs = 3'b001;
			end else begin
				knobs = 3'($urandom_range(0, 7));
			end
			apply_settings(knobs);
			phase_start = words_offered;
			while (words_offered - phase_start < WORDS_PER_PHASE) send_random_header();
			drain_and_settle();
		end

		$display("Run sent %0d random headers plus directed words: %0d words taken, %0d result",
			headers_sent, words_taken, results_checked);
		$display("words checked, %0d verdicts with an error status, %0d register settings",
			failed_verdicts, settings_applied);
		if (mismatches == 0 && header_results_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d result words never arrived", mismatches,
				header_results_due.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hhfv_pkg.sv
hw/rtl/hhfv_ctrl.sv
hw/rtl/hhfv_dp.sv
hw/rtl/http_header_field_validator_top.sv
verif/http_header_field_validator_top_tb.sv
